/* hdl/assert_macros.svh */
// assertion helpers shared by the block's modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/bsca_pkg.sv */
package bsca_pkg;

	// default sizing
	localparam int MAX_BINS_DEF  = 256;
	localparam int SUM_WIDTH_DEF = 48;

	// fixed field widths
	localparam int POINT_W   = 32;
	localparam int COUNT_W   = 32;
	localparam int DIVISOR_W = 32;
	localparam int OUT_SUM_W = 48;
	localparam int BIN_IN_W  = 8;
	localparam int NBINS_W   = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BINS       = 2'd2;

	// register reset values
	localparam logic signed [POINT_W-1:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [POINT_W-1:0] RANGE_HIGH_RST = 32'sd65536;
	localparam logic [NBINS_W-1:0]        BINS_RST       = 9'd256;

	// count saturation value
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_ADD       = 2'd0,
		CMD_SET_SUM   = 2'd1,
		CMD_SET_COUNT = 2'd2,
		CMD_READ      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_BAD_BIN      = 2'd1,
		STS_OUT_OF_RANGE = 2'd2
	} status_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hdl/bsca_ram.sv */
module bsca_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/bsca_divider.sv */
`include "assert_macros.svh"

module bsca_divider #(
	parameter int DIV_W = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [DIV_W-1:0]                   dividend,
	input  logic [bsca_pkg::DIVISOR_W-1:0]     divisor,
	output logic [DIV_W-1:0]                   quotient,
	output bsca_pkg::div_stat_t                stat
);

	localparam int DVS_W = bsca_pkg::DIVISOR_W;
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   sub;
	logic             ge;

	// one restoring step: bring in the next dividend bit, try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		sub     = shifted - {1'b0, dvs_q};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	// one quotient bit per cycle, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				cnt_q  <= CNT_W'(DIV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? sub[DVS_W-1:0] : shifted[DVS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`ASSERT_NEVER(a_no_restart, clk, arst_n, start && busy_q, "divider restarted while busy")
	`ASSERT_PROP(a_rem_below_divisor, clk, arst_n, done_q |-> (rem_q < dvs_q), "remainder not below divisor")

endmodule

/* hdl/binned_sum_count_accumulator.sv */
// Binned sum-and-count accumulator. Pulse start while busy is low to issue one
// command (add sample, set bin sum, set bin count, read bin); busy stays high
// until the single result is shown on the result ports with result_valid high
// for exactly one cycle, and the receiver cannot stall it. A shared restoring
// divider producing one quotient bit per cycle sets the rate; DIV_W, its width,
// is the larger of SUM_WIDTH and 32 plus the bin-count width (48 at the
// defaults). An add runs two divides, the bin index and then the mean; set and
// read run only the mean divide, and none for a bin whose count is zero. A point
// exactly on the upper edge ends after the index divide, and a bad bin or a point
// outside the range ends right after the check. Busy falls the cycle after the
// strobe, so the next command can be taken once busy is low.
// After reset the bin store is cleared one entry per cycle with busy high;
// configuration writes are taken at any time (cfg_ready is always high) but must
// only be issued while the block is idle.
`include "assert_macros.svh"

module binned_sum_count_accumulator #(
	parameter int MAX_BINS  = bsca_pkg::MAX_BINS_DEF,
	parameter int SUM_WIDTH = bsca_pkg::SUM_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// command channel
	input  logic                                    start,
	output logic                                    busy,
	input  logic [1:0]                              command,
	input  logic signed [bsca_pkg::POINT_W-1:0]     sample_point,
	input  logic signed [bsca_pkg::POINT_W-1:0]     sample_value,
	input  logic [bsca_pkg::BIN_IN_W-1:0]           bin_index,
	input  logic signed [bsca_pkg::OUT_SUM_W-1:0]   new_sum,
	input  logic [bsca_pkg::COUNT_W-1:0]            new_count,
	// result channel
	output logic                                    result_valid,
	output logic [1:0]                              status,
	output logic [bsca_pkg::BIN_IN_W-1:0]           bin_used,
	output logic signed [bsca_pkg::OUT_SUM_W-1:0]   bin_total,
	output logic [bsca_pkg::COUNT_W-1:0]            bin_samples,
	output logic signed [bsca_pkg::OUT_SUM_W-1:0]   bin_mean,
	// configuration channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [bsca_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bsca_pkg::CFG_DAT_W-1:0]          cfg_data
);

	localparam int SUM_W  = SUM_WIDTH;
	localparam int CNT_W  = bsca_pkg::COUNT_W;
	localparam int PT_W   = bsca_pkg::POINT_W;
	localparam int OUT_W  = bsca_pkg::OUT_SUM_W;
	localparam int BIN_W  = $clog2(MAX_BINS);
	localparam int NB_W   = $clog2(MAX_BINS + 1);
	localparam int PROD_W = PT_W + NB_W;
	localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
	localparam int WORD_W = SUM_W + CNT_W;
	localparam int EXT_W  = 65;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [10:0] {
		ST_CLEAR     = 11'b000_0000_0001,
		ST_IDLE      = 11'b000_0000_0010,
		ST_CHECK     = 11'b000_0000_0100,
		ST_MUL       = 11'b000_0000_1000,
		ST_IDX_GO    = 11'b000_0001_0000,
		ST_IDX_WAIT  = 11'b000_0010_0000,
		ST_LOOKUP    = 11'b000_0100_0000,
		ST_UPDATE    = 11'b000_1000_0000,
		ST_MEAN_GO   = 11'b001_0000_0000,
		ST_MEAN_WAIT = 11'b010_0000_0000,
		ST_DONE      = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [PT_W-1:0]          range_low_q;
	logic signed [PT_W-1:0]          range_high_q;
	logic [bsca_pkg::NBINS_W-1:0]    bins_q;

	// latched command
	bsca_pkg::cmd_t                  cmd_q;
	logic signed [PT_W-1:0]          point_q;
	logic signed [PT_W-1:0]          value_q;
	logic [bsca_pkg::BIN_IN_W-1:0]   index_q;
	logic signed [OUT_W-1:0]         new_sum_q;
	logic [CNT_W-1:0]                new_count_q;

	// working registers
	logic [BIN_W-1:0]                clr_q;
	logic [BIN_W-1:0]                bin_q;
	logic [PT_W-1:0]                 diff_q;
	logic [PT_W-1:0]                 span_q;
	logic [PROD_W-1:0]               prod_q;
	logic signed [SUM_W-1:0]         sum_q;
	logic [CNT_W-1:0]                cnt_q;

	// result registers
	bsca_pkg::status_t               status_q;
	logic [bsca_pkg::BIN_IN_W-1:0]   bin_used_q;
	logic [OUT_W-1:0]                total_q;
	logic [CNT_W-1:0]                samples_q;
	logic [OUT_W-1:0]                mean_q;

	// memory and divider hookup
	logic                            ram_we;
	logic [BIN_W-1:0]                ram_waddr;
	logic [WORD_W-1:0]               ram_wdata;
	logic                            ram_re;
	logic [WORD_W-1:0]               ram_rdata;
	logic                            div_start;
	logic [DIV_W-1:0]                div_dividend;
	logic [bsca_pkg::DIVISOR_W-1:0]  div_divisor;
	logic [DIV_W-1:0]                div_quo;
	bsca_pkg::div_stat_t             div_stat;

	// combinational helpers
	logic [NB_W-1:0]                 nb;
	logic                            point_bad;
	logic signed [PT_W:0]            diff_w;
	logic signed [PT_W:0]            span_w;
	logic signed [SUM_W-1:0]         cur_sum;
	logic [CNT_W-1:0]                cur_cnt;
	logic signed [SUM_W:0]           add_w;
	logic signed [SUM_W-1:0]         add_sat;
	logic [CNT_W-1:0]                cnt_inc;
	logic signed [EXT_W-1:0]         ns_ext;
	logic signed [SUM_W-1:0]         ns_sat;
	logic signed [SUM_W-1:0]         upd_sum;
	logic [CNT_W-1:0]                upd_cnt;
	logic signed [EXT_W-1:0]         tot_ext;
	logic                            sum_neg;
	logic [SUM_W-1:0]                sum_mag;
	logic [EXT_W-1:0]                mean_ext;

	// active bin count, zero taken as one and clamped to the store depth
	always_comb begin
		if (bins_q == '0) begin
			nb = NB_W'(1);
		end else if (32'(bins_q) > 32'(MAX_BINS)) begin
			nb = NB_W'(MAX_BINS);
		end else begin
			nb = NB_W'(bins_q);
		end
	end

	// range test and offsets for the add command
	always_comb begin
		point_bad = (range_high_q <= range_low_q) || (point_q < range_low_q)
			|| (point_q > range_high_q);
		diff_w    = (PT_W+1)'(point_q) - (PT_W+1)'(range_low_q);
		span_w    = (PT_W+1)'(range_high_q) - (PT_W+1)'(range_low_q);
	end

	// bin update: saturating add, saturating count, clamped overwrite
	always_comb begin
		cur_sum = $signed(ram_rdata[WORD_W-1:CNT_W]);
		cur_cnt = ram_rdata[CNT_W-1:0];
		add_w   = (SUM_W+1)'(cur_sum) + (SUM_W+1)'(value_q);
		if (add_w[SUM_W] != add_w[SUM_W-1]) begin
			add_sat = add_w[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			add_sat = SUM_W'(add_w);
		end
		cnt_inc = (cur_cnt == bsca_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);
		ns_ext  = EXT_W'(new_sum_q);
		if (ns_ext > EXT_W'(SUM_MAX)) begin
			ns_sat = SUM_MAX;
		end else if (ns_ext < EXT_W'(SUM_MIN)) begin
			ns_sat = SUM_MIN;
		end else begin
			ns_sat = SUM_W'(ns_ext);
		end
		case (cmd_q)
			bsca_pkg::CMD_ADD: begin
				upd_sum = add_sat;
				upd_cnt = cnt_inc;
			end
			bsca_pkg::CMD_SET_SUM: begin
				upd_sum = ns_sat;
				upd_cnt = cur_cnt;
			end
			bsca_pkg::CMD_SET_COUNT: begin
				upd_sum = cur_sum;
				upd_cnt = new_count_q;
			end
			default: begin
				upd_sum = cur_sum;
				upd_cnt = cur_cnt;
			end
		endcase
		tot_ext = EXT_W'(upd_sum);
	end

	// signed mean from the unsigned quotient of the magnitude
	always_comb begin
		sum_neg  = sum_q[SUM_W-1];
		sum_mag  = sum_neg ? (SUM_W'(0) - sum_q) : sum_q;
		mean_ext = sum_neg ? (EXT_W'(0) - EXT_W'(div_quo)) : EXT_W'(div_quo);
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bin_q;
		ram_wdata = {upd_sum, upd_cnt};
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_UPDATE && cmd_q != bsca_pkg::CMD_READ) begin
			ram_we = 1'b1;
		end
		ram_re = (state_q == ST_LOOKUP);
	end

	// divider operand selection: bin index first, then the mean
	always_comb begin
		div_start = (state_q == ST_IDX_GO) || (state_q == ST_MEAN_GO);
		if (state_q == ST_MEAN_GO) begin
			div_dividend = DIV_W'(sum_mag);
			div_divisor  = cnt_q;
		end else begin
			div_dividend = DIV_W'(prod_q);
			div_divisor  = span_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= bsca_pkg::RANGE_LOW_RST;
			range_high_q <= bsca_pkg::RANGE_HIGH_RST;
			bins_q       <= bsca_pkg::BINS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsca_pkg::REG_RANGE_LOW:  range_low_q  <= $signed(cfg_data[PT_W-1:0]);
				bsca_pkg::REG_RANGE_HIGH: range_high_q <= $signed(cfg_data[PT_W-1:0]);
				bsca_pkg::REG_BINS:       bins_q       <= cfg_data[bsca_pkg::NBINS_W-1:0];
				default: ;
			endcase
		end
	end

	// command latch on accept
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q       <= bsca_pkg::cmd_t'(command);
			point_q     <= sample_point;
			value_q     <= sample_value;
			index_q     <= bin_index;
			new_sum_q   <= new_sum;
			new_count_q <= new_count;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + BIN_W'(1);
					if (clr_q == BIN_W'(MAX_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (cmd_q == bsca_pkg::CMD_ADD) begin
						diff_q <= diff_w[PT_W-1:0];
						span_q <= span_w[PT_W-1:0];
						if (point_bad) begin
							status_q   <= bsca_pkg::STS_OUT_OF_RANGE;
							bin_used_q <= '0;
							total_q    <= '0;
							samples_q  <= '0;
							mean_q     <= '0;
							state_q    <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end else if (32'(index_q) >= 32'(nb)) begin
						status_q   <= bsca_pkg::STS_BAD_BIN;
						bin_used_q <= index_q;
						total_q    <= '0;
						samples_q  <= '0;
						mean_q     <= '0;
						state_q    <= ST_DONE;
					end else begin
						bin_q   <= BIN_W'(index_q);
						state_q <= ST_LOOKUP;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(diff_q) * PROD_W'(nb);
					state_q <= ST_IDX_GO;
				end
				ST_IDX_GO: begin
					state_q <= ST_IDX_WAIT;
				end
				ST_IDX_WAIT: begin
					if (div_stat.done) begin
						// a point exactly at the upper edge lands past the last bin
						if (div_quo >= DIV_W'(nb)) begin
							status_q   <= bsca_pkg::STS_OUT_OF_RANGE;
							bin_used_q <= '0;
							total_q    <= '0;
							samples_q  <= '0;
							mean_q     <= '0;
							state_q    <= ST_DONE;
						end else begin
							bin_q   <= BIN_W'(div_quo);
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					sum_q      <= upd_sum;
					cnt_q      <= upd_cnt;
					status_q   <= bsca_pkg::STS_OK;
					bin_used_q <= bsca_pkg::BIN_IN_W'(bin_q);
					total_q    <= tot_ext[OUT_W-1:0];
					samples_q  <= upd_cnt;
					if (upd_cnt == '0) begin
						mean_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MEAN_GO;
					end
				end
				ST_MEAN_GO: begin
					state_q <= ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (div_stat.done) begin
						mean_q  <= mean_ext[OUT_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	bsca_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_BINS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (bin_q),
		.rd_data (ram_rdata)
	);

	bsca_divider #(
		.DIV_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// outputs
	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DONE);
	assign status       = status_q;
	assign bin_used     = bin_used_q;
	assign bin_total    = $signed(total_q);
	assign bin_samples  = samples_q;
	assign bin_mean     = $signed(mean_q);
	assign cfg_ready    = 1'b1;

	`ASSERT_PROP(a_accept_to_check, clk, arst_n, (start && !busy) |=> (state_q == ST_CHECK), "accepted transaction did not enter check")
	`ASSERT_PROP(a_single_strobe, clk, arst_n, result_valid |=> !result_valid, "result strobe longer than one cycle")
	`ASSERT_PROP(a_write_in_range, clk, arst_n, (ram_we && state_q == ST_UPDATE) |-> (32'(bin_q) < 32'(nb)), "bin write beyond active bins")

endmodule

/* bench/bsca_checker.sv */
`timescale 1ns / 1ps

module bsca_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic [1:0]                            command,
	input  logic signed [bsca_pkg::POINT_W-1:0]   sample_point,
	input  logic signed [bsca_pkg::POINT_W-1:0]   sample_value,
	input  logic [bsca_pkg::BIN_IN_W-1:0]         bin_index,
	input  logic signed [bsca_pkg::OUT_SUM_W-1:0] new_sum,
	input  logic [bsca_pkg::COUNT_W-1:0]          new_count,
	input  logic                                  result_valid,
	input  logic [1:0]                            status,
	input  logic [bsca_pkg::BIN_IN_W-1:0]         bin_used,
	input  logic signed [bsca_pkg::OUT_SUM_W-1:0] bin_total,
	input  logic [bsca_pkg::COUNT_W-1:0]          bin_samples,
	input  logic signed [bsca_pkg::OUT_SUM_W-1:0] bin_mean,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [bsca_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bsca_pkg::CFG_DAT_W-1:0]        cfg_data,
	output int unsigned                           mismatches,
	output int unsigned                           in_flight
);
	import bsca_pkg::*;

	localparam int     NUM_BINS   = MAX_BINS_DEF;
	localparam longint SUM_HI     = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO     = -SUM_HI - 64'sd1;

	typedef struct packed {
		status_t     status;
		logic [7:0]  bin;
		logic [47:0] total;
		logic [31:0] samples;
		logic [47:0] mean;
	} bin_report_t;

	// predicted bin store and registers
	longint            bin_sum_q [NUM_BINS];
	logic [31:0]       bin_cnt_q [NUM_BINS];
	logic signed [31:0] low_edge;
	logic signed [31:0] high_edge;
	logic [8:0]        nbins_reg;
	bin_report_t       awaited_q [$];

	// bin count as the block uses it
	function automatic int unsigned bins_active();
		if (nbins_reg == 9'd0)
			return 1;
		if (nbins_reg > NUM_BINS)
			return NUM_BINS;
		return nbins_reg;
	endfunction

	// quotient truncated toward zero, zero for an empty bin
	function automatic longint mean_of(longint s, logic [31:0] c);
		if (c == 32'd0)
			return 0;
		return s / longint'(c);
	endfunction

	// apply one command to the predicted store and return what it reports
	function automatic bin_report_t apply_command(cmd_t cmd, logic signed [31:0] p,
			logic signed [31:0] v, logic [7:0] idx, logic signed [47:0] s_in,
			logic [31:0] c_in);
		bin_report_t r;
		longint      lo;
		longint      hi;
		longint      slot;
		longint      total;
		longint      avg;
		int unsigned nb;
		logic [7:0]  bin;
		r = '0;
		nb = bins_active();
		if (cmd == CMD_ADD) begin
			lo = low_edge;
			hi = high_edge;
			if (hi <= lo || longint'(p) < lo || longint'(p) > hi) begin
				r.status = STS_OUT_OF_RANGE;
				return r;
			end
			slot = (longint'(p) - lo) * longint'(nb) / (hi - lo);
			// a point right on the upper edge lands past the last bin
			if (slot >= longint'(nb)) begin
				r.status = STS_OUT_OF_RANGE;
				return r;
			end
			bin = slot[7:0];
			total = bin_sum_q[bin] + longint'(v);
			if (total > SUM_HI)
				total = SUM_HI;
			else if (total < SUM_LO)
				total = SUM_LO;
			bin_sum_q[bin] = total;
			if (bin_cnt_q[bin] != COUNT_MAX)
				bin_cnt_q[bin] = bin_cnt_q[bin] + 32'd1;
		end else begin
			bin = idx;
			if (int'(idx) >= nb) begin
				r.status = STS_BAD_BIN;
				r.bin = idx;
				return r;
			end
			case (cmd)
				CMD_SET_SUM:   bin_sum_q[idx] = longint'(s_in);
				CMD_SET_COUNT: bin_cnt_q[idx] = c_in;
				default:       ;
			endcase
		end
		avg = mean_of(bin_sum_q[bin], bin_cnt_q[bin]);
		r.status = STS_OK;
		r.bin = bin;
		r.total = bin_sum_q[bin][47:0];
		r.samples = bin_cnt_q[bin];
		r.mean = avg[47:0];
		return r;
	endfunction

	// one line per mismatch, and count it
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("@%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// watch result, command and register transactions
	always @(posedge clk or negedge arst_n) begin
		bin_report_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bin_sum_q[i] = 0;
				bin_cnt_q[i] = '0;
			end
			low_edge = RANGE_LOW_RST;
			high_edge = RANGE_HIGH_RST;
			nbins_reg = BINS_RST;
			awaited_q.delete();
			mismatches = 0;
			in_flight = 0;
		end else begin
			// result transaction against the oldest awaited one
			if (result_valid) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("result with nothing awaited", bin_used, 64'd0);
				end else begin
					want = awaited_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (bin_used !== want.bin)
						report_mismatch("bin_used", bin_used, want.bin);
					if (bin_total !== want.total)
						report_mismatch("bin_total", bin_total, want.total);
					if (bin_samples !== want.samples)
						report_mismatch("bin_samples", bin_samples, want.samples);
					if (bin_mean !== want.mean)
						report_mismatch("bin_mean", bin_mean, want.mean);
				end
			end
			// command transaction
			if (start && !busy)
				awaited_q.push_back(apply_command(cmd_t'(command), sample_point,
					sample_value, bin_index, new_sum, new_count));
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RANGE_LOW:  low_edge = cfg_data;
					REG_RANGE_HIGH: high_edge = cfg_data;
					REG_BINS:       nbins_reg = cfg_data[8:0];
					default:        ;
				endcase
			end
			in_flight = awaited_q.size();
		end
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import bsca_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  command;
	logic signed [POINT_W-1:0]   sample_point;
	logic signed [POINT_W-1:0]   sample_value;
	logic [BIN_IN_W-1:0]         bin_index;
	logic signed [OUT_SUM_W-1:0] new_sum;
	logic [COUNT_W-1:0]          new_count;
	logic                        result_valid;
	logic [1:0]                  status;
	logic [BIN_IN_W-1:0]         bin_used;
	logic signed [OUT_SUM_W-1:0] bin_total;
	logic [COUNT_W-1:0]          bin_samples;
	logic signed [OUT_SUM_W-1:0] bin_mean;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DAT_W-1:0]        cfg_data;
	int unsigned                 mismatches;
	int unsigned                 in_flight;
	int unsigned                 cycle_count = 0;
	int unsigned                 issued;
	// programmed range, kept to aim the random points
	logic signed [31:0]          cur_low;
	logic signed [31:0]          cur_high;
	int unsigned                 cur_bins;

	binned_sum_count_accumulator uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.sample_point(sample_point),
		.sample_value(sample_value),
		.bin_index   (bin_index),
		.new_sum     (new_sum),
		.new_count   (new_count),
		.result_valid(result_valid),
		.status      (status),
		.bin_used    (bin_used),
		.bin_total   (bin_total),
		.bin_samples (bin_samples),
		.bin_mean    (bin_mean),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	bsca_checker bin_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.sample_point(sample_point),
		.sample_value(sample_value),
		.bin_index   (bin_index),
		.new_sum     (new_sum),
		.new_count   (new_count),
		.result_valid(result_valid),
		.status      (status),
		.bin_used    (bin_used),
		.bin_total   (bin_total),
		.bin_samples (bin_samples),
		.bin_mean    (bin_mean),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.in_flight   (in_flight)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic logic [47:0] any48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// one command transaction, with an occasional idle gap before it
	task automatic issue(cmd_t cmd, logic signed [31:0] p, logic signed [31:0] v,
			logic [7:0] idx, logic signed [47:0] s, logic [31:0] c);
		int unsigned gap;
		@(negedge clk);
		if ((issued < 400 || issued >= 600) && $urandom_range(99) < 14) begin
			gap = ($urandom_range(3) == 0) ? $urandom_range(120, 5) : $urandom_range(4, 1);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		command = cmd;
		sample_point = p;
		sample_value = v;
		bin_index = idx;
		new_sum = s;
		new_count = c;
		do @(posedge clk); while (busy);
		issued++;
	endtask

	task automatic add_sample(logic signed [31:0] p, logic signed [31:0] v);
		issue(CMD_ADD, p, v, 8'($urandom), any48(), $urandom);
	endtask

	task automatic set_sum(logic [7:0] idx, logic signed [47:0] s);
		issue(CMD_SET_SUM, $urandom, $urandom, idx, s, $urandom);
	endtask

	task automatic set_count(logic [7:0] idx, logic [31:0] c);
		issue(CMD_SET_COUNT, $urandom, $urandom, idx, any48(), c);
	endtask

	task automatic read_bin(logic [7:0] idx);
		issue(CMD_READ, $urandom, $urandom, idx, any48(), $urandom);
	endtask

	// hold off until every awaited result is back and the block is idle
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (in_flight != 0 || busy)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// reprogram all three registers while idle
	task automatic set_range(logic signed [31:0] lo, logic signed [31:0] hi, logic [8:0] nb);
		logic [31:0] word;
		settle();
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		// upper bits of the bin count word are junk the block must ignore
		word = $urandom;
		word[8:0] = nb;
		write_reg(REG_BINS, word);
		cur_low = lo;
		cur_high = hi;
		cur_bins = (nb == 9'd0) ? 1 : (nb > 9'd256) ? 256 : nb;
	endtask

	task automatic random_range(logic [8:0] nb);
		logic signed [31:0] a;
		logic signed [31:0] b;
		a = $urandom;
		b = $urandom;
		if (a == b)
			b = a ^ 32'd1;
		if (a < b)
			set_range(a, b, nb);
		else
			set_range(b, a, nb);
	endtask

	// mostly in-range points and live bins, with extremes of sum and count mixed in
	task automatic random_item();
		int unsigned        pick;
		longint             span;
		logic signed [31:0] p;
		logic [7:0]         idx;
		logic signed [47:0] s;
		logic [31:0]        c;
		span = longint'(cur_high) - longint'(cur_low);
		pick = $urandom_range(99);
		if (span > 0 && pick < 85)
			p = cur_low + 32'($urandom_range(32'(span)));
		else if (pick < 90)
			p = cur_high;
		else
			p = $urandom;
		if ($urandom_range(9) < 8)
			idx = 8'($urandom_range(cur_bins - 1));
		else
			idx = 8'($urandom);
		case ($urandom_range(5))
			0:       s = SUM_MAX;
			1:       s = SUM_MIN;
			2:       s = SUM_MAX - 48'($urandom_range(65536));
			3:       s = SUM_MIN + 48'($urandom_range(65536));
			default: s = any48();
		endcase
		case ($urandom_range(3))
			0:       c = COUNT_MAX - 32'($urandom_range(2));
			1:       c = 32'($urandom_range(10));
			default: c = $urandom;
		endcase
		pick = $urandom_range(99);
		if (pick < 50)
			add_sample(p, $urandom);
		else if (pick < 65)
			set_sum(idx, s);
		else if (pick < 80)
			set_count(idx, c);
		else
			read_bin(idx);
		// now and then let everything drain before going on
		if ($urandom_range(79) == 0)
			settle();
	endtask

	// stimulus and verdict
	initial begin
		int                 n;
		logic signed [31:0] a;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_ADD;
		sample_point = '0;
		sample_value = '0;
		bin_index = '0;
		new_sum = '0;
		new_count = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RANGE_LOW;
		cfg_data = '0;
		issued = 0;
		cur_low = RANGE_LOW_RST;
		cur_high = RANGE_HIGH_RST;
		cur_bins = BINS_RST;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset range [0, 1.0) in 256 bins: edges, saturation, empty and negative means
		add_sample(32'sd0, 32'sh7FFFFFFF);
		add_sample(32'sd65535, 32'sh80000000);
		add_sample(32'sd65536, 32'sd1);
		add_sample(-32'sd1, 32'sd1);
		add_sample(32'sh7FFFFFFF, 32'sd1);
		add_sample(32'sh80000000, 32'sd1);
		set_sum(8'd3, SUM_MAX);
		add_sample(32'sd768, 32'sd1);
		set_sum(8'd4, SUM_MIN);
		add_sample(32'sd1024, -32'sd1);
		set_count(8'd5, COUNT_MAX);
		add_sample(32'sd1280, 32'sd5);
		read_bin(8'd10);
		set_count(8'd3, 32'd3);
		set_count(8'd4, 32'd7);
		set_sum(8'd255, -48'sd3);
		set_count(8'd255, 32'd2);
		read_bin(8'd255);

		// single bin, then a zero bin count taken as one
		set_range(RANGE_LOW_RST, RANGE_HIGH_RST, 9'd1);
		read_bin(8'd1);
		set_sum(8'd200, 48'sd5);
		add_sample(32'sd65535, 32'sd9);
		set_range(RANGE_LOW_RST, RANGE_HIGH_RST, 9'd0);
		read_bin(8'd255);
		add_sample(32'sd0, 32'sd3);

		// random phases under different range and bin settings
		for (int ph = 0; ph < 9; ph++) begin
			n = 150;
			case (ph)
				0: set_range(32'sh80000000, 32'sh7FFFFFFF, 9'd256);
				1: set_range(-32'sd1000, 32'sd1000, 9'd511);
				2: begin
					set_range(32'sd5000, -32'sd5000, 9'd0);
					n = 20;
				end
				3: random_range(9'($urandom_range(511)));
				4: random_range(9'd1);
				5: begin
					a = $urandom;
					set_range(a, a, 9'd17);
					n = 20;
				end
				6: begin
					a = 32'($urandom_range(1000000)) - 32'sd500000;
					set_range(a, a + 32'($urandom_range(600, 1)), 9'($urandom_range(256, 1)));
				end
				7: random_range(9'd257);
				default: set_range(RANGE_LOW_RST, RANGE_HIGH_RST, BINS_RST);
			endcase
			repeat (n) random_item();
		end

		settle();
		repeat (150) @(negedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
